// ===== design/iee_pkg.sv =====
package iee_pkg;

  // Number format: signed two's complement with a binary point.
  localparam int VALUE_WIDTH    = 48;
  localparam int FRACTION_BITS  = 16;
  localparam int ACTION_WIDTH   = 3;

  // The divider shifts the dividend magnitude left by the fraction bits.
  localparam int SHIFT_WIDTH    = VALUE_WIDTH + FRACTION_BITS;
  localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
  localparam int MAG_WIDTH      = (PROD_WIDTH > SHIFT_WIDTH) ? PROD_WIDTH : SHIFT_WIDTH;
  localparam int CNT_WIDTH      = $clog2(SHIFT_WIDTH);

  typedef logic signed [VALUE_WIDTH-1:0]  value_t;
  typedef logic        [VALUE_WIDTH-1:0]  mag_t;
  typedef logic        [ACTION_WIDTH-1:0] action_t;

  localparam action_t ACT_PLUS   = ACTION_WIDTH'(0);
  localparam action_t ACT_MINUS  = ACTION_WIDTH'(1);
  localparam action_t ACT_MUL    = ACTION_WIDTH'(2);
  localparam action_t ACT_DIV    = ACTION_WIDTH'(3);
  localparam action_t ACT_EQUALS = ACTION_WIDTH'(4);

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    POP_NONE,
    POP_MUL,
    POP_DIV
  } pop_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARITH,
    ST_POST,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // Unsigned magnitude; the most negative value maps onto its own bit pattern.
  function automatic mag_t magnitude(value_t v);
    return v[VALUE_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

// ===== design/iee_if.sv =====
interface iee_in_if;
  logic              valid;
  logic              ready;
  iee_pkg::value_t   operand_value;
  iee_pkg::action_t  action;

  modport source (output valid, operand_value, action, input ready);
  modport sink   (input valid, operand_value, action, output ready);
endinterface

interface iee_out_if;
  logic              valid;
  logic              ready;
  iee_pkg::value_t   result_value;
  logic              divide_by_zero;

  modport source (output valid, result_value, divide_by_zero, input ready);
  modport sink   (input valid, result_value, divide_by_zero, output ready);
endinterface

// ===== design/iee_muldiv.sv =====
module iee_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  iee_pkg::md_req_t req_i,
  input  iee_pkg::value_t  a_i,
  input  iee_pkg::value_t  b_i,
  output logic             done_o,
  output iee_pkg::value_t  res_o
);

  localparam int W  = iee_pkg::VALUE_WIDTH;
  localparam int SH = iee_pkg::SHIFT_WIDTH;
  localparam int MW = iee_pkg::MAG_WIDTH;

  iee_pkg::md_state_e            state_q, state_d;
  logic [iee_pkg::CNT_WIDTH-1:0] cnt_q, cnt_d;
  iee_pkg::mag_t                 acc_q, acc_d;
  iee_pkg::mag_t                 dvs_q, dvs_d;
  logic [SH-1:0]                 shreg_q, shreg_d;
  logic                          neg_q, neg_d;
  logic                          div_q, div_d;

  logic [W:0]   madd;
  logic [W:0]   rem2;
  logic [W+1:0] rdiff;
  logic         ge;
  logic [MW-1:0] mag_full;
  logic [MW-1:0] limit;
  logic          over;

  // One multiplier bit or one quotient bit per cycle.
  always_comb begin
    madd  = {1'b0, acc_q} + {1'b0, (shreg_q[0] ? dvs_q : '0)};
    rem2  = {acc_q, shreg_q[SH-1]};
    rdiff = {1'b0, rem2} - {2'b00, dvs_q};
    ge    = ~rdiff[W+1];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      iee_pkg::MD_IDLE: begin
        if (req_i.start) begin
          state_d = iee_pkg::MD_RUN;
        end
      end
      iee_pkg::MD_RUN: begin
        if (cnt_q == '0) begin
          state_d = iee_pkg::MD_DONE;
        end
      end
      iee_pkg::MD_DONE: state_d = iee_pkg::MD_IDLE;
      default:          state_d = iee_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    dvs_d   = dvs_q;
    shreg_d = shreg_q;
    neg_d   = neg_q;
    div_d   = div_q;
    case (state_q)
      iee_pkg::MD_IDLE: begin
        if (req_i.start) begin
          neg_d = a_i[W-1] ^ b_i[W-1];
          div_d = req_i.is_div;
          acc_d = '0;
          if (req_i.is_div) begin
            dvs_d   = iee_pkg::magnitude(b_i);
            shreg_d = SH'(iee_pkg::magnitude(a_i)) << iee_pkg::FRACTION_BITS;
            cnt_d   = iee_pkg::CNT_WIDTH'(SH - 1);
          end else begin
            dvs_d   = iee_pkg::magnitude(a_i);
            shreg_d = SH'(iee_pkg::magnitude(b_i));
            cnt_d   = iee_pkg::CNT_WIDTH'(W - 1);
          end
        end
      end
      iee_pkg::MD_RUN: begin
        cnt_d = cnt_q - 1'b1;
        if (div_q) begin
          acc_d   = ge ? rdiff[W-1:0] : rem2[W-1:0];
          shreg_d = {shreg_q[SH-2:0], ge};
        end else begin
          acc_d        = madd[W:1];
          shreg_d      = shreg_q >> 1;
          shreg_d[W-1] = madd[0];
        end
      end
      default: ;
    endcase
  end

  // Saturate the magnitude against the limit of the result's sign.
  always_comb begin
    if (div_q) begin
      mag_full = MW'(shreg_q);
    end else begin
      mag_full = MW'({acc_q, shreg_q[W-1:0]} >> iee_pkg::FRACTION_BITS);
    end
    limit = neg_q ? MW'(iee_pkg::mag_t'(iee_pkg::VALUE_MIN))
                  : MW'(iee_pkg::mag_t'(iee_pkg::VALUE_MAX));
    over  = mag_full > limit;
    if (over) begin
      res_o = neg_q ? iee_pkg::VALUE_MIN : iee_pkg::VALUE_MAX;
    end else if (neg_q) begin
      res_o = -iee_pkg::value_t'(mag_full[W-1:0]);
    end else begin
      res_o = iee_pkg::value_t'(mag_full[W-1:0]);
    end
  end

  assign done_o = (state_q == iee_pkg::MD_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iee_pkg::MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    dvs_q   <= dvs_d;
    shreg_q <= shreg_d;
    neg_q   <= neg_d;
    div_q   <= div_d;
  end

endmodule

// ===== design/infix_expression_evaluator.sv =====
// Channel  Dir  Fields                          Handshake
// in_i     in   operand_value[47:0], action[2:0]  valid/ready
// out_o    out  result_value[47:0], divide_by_zero valid/ready
//
// An item that completes a pending multiply, or a divide by a nonzero operand,
// passes through the serial multiply/divide unit and then the post step before
// the next item can be taken; any other valid item passes through the post step
// only, and equals adds the emit step, which loads the result. The serial unit
// retires one multiplier bit or one quotient bit per cycle.
// Items with the unused action codes 5 to 7 are taken and dropped.
// Reset clears all expression state and any result held on the output.
// A stalled output holds its result; the next item is still accepted, and only
// a second equals waits until the first result has been taken.

module infix_expression_evaluator (
  input  logic             clk_i,
  input  logic             rst_ni,
  iee_in_if.sink           in_i,
  iee_out_if.source        out_o
);

  localparam int W = iee_pkg::VALUE_WIDTH;

  iee_pkg::state_e   state_q, state_d;
  iee_pkg::value_t   sum_q, sum_d;
  iee_pkg::value_t   term_q, term_d;
  logic              psub_q, psub_d;
  iee_pkg::pop_e     pop_q, pop_d;
  logic              err_q, err_d;
  iee_pkg::action_t  act_q, act_d;

  logic              out_valid_q, out_valid_d;
  iee_pkg::value_t   out_value_q, out_value_d;
  logic              out_dbz_q, out_dbz_d;

  logic              accept;
  logic              act_valid;
  logic              x_zero;
  logic              emit_go;
  logic              need_arith;
  iee_pkg::md_req_t  md_req;
  logic              md_done;
  iee_pkg::value_t   md_res;

  logic [W:0]        sum_a;
  logic [W:0]        sum_b;
  logic [W:0]        sum_raw;
  iee_pkg::value_t   sum_sat;

  assign in_i.ready = (state_q == iee_pkg::ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign act_valid  = in_i.action inside {[iee_pkg::ACT_PLUS:iee_pkg::ACT_EQUALS]};
  assign x_zero     = (in_i.operand_value == '0);
  assign emit_go    = (state_q == iee_pkg::ST_EMIT) && (!out_valid_q || out_o.ready);

  // A pending multiply, or a pending divide by a nonzero operand, needs the
  // serial unit; everything else settles the product term at once.
  assign need_arith = (pop_q == iee_pkg::POP_MUL) ||
                      ((pop_q == iee_pkg::POP_DIV) && !x_zero);

  assign md_req.start  = accept && act_valid && need_arith;
  assign md_req.is_div = (pop_q == iee_pkg::POP_DIV);

  iee_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (term_q),
    .b_i    (in_i.operand_value),
    .done_o (md_done),
    .res_o  (md_res)
  );

  // Saturating add or subtract of the product term into the running sum.
  always_comb begin
    sum_a   = {sum_q[W-1], sum_q};
    sum_b   = {term_q[W-1], term_q};
    sum_raw = psub_q ? (sum_a - sum_b) : (sum_a + sum_b);
    if (sum_raw[W] != sum_raw[W-1]) begin
      sum_sat = sum_raw[W] ? iee_pkg::VALUE_MIN : iee_pkg::VALUE_MAX;
    end else begin
      sum_sat = iee_pkg::value_t'(sum_raw[W-1:0]);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      iee_pkg::ST_IDLE: begin
        if (accept && act_valid) begin
          state_d = need_arith ? iee_pkg::ST_ARITH : iee_pkg::ST_POST;
        end
      end
      iee_pkg::ST_ARITH: begin
        if (md_done) begin
          state_d = iee_pkg::ST_POST;
        end
      end
      iee_pkg::ST_POST: begin
        state_d = (act_q == iee_pkg::ACT_EQUALS) ? iee_pkg::ST_EMIT : iee_pkg::ST_IDLE;
      end
      iee_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_d = iee_pkg::ST_IDLE;
        end
      end
      default: state_d = iee_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sum_d       = sum_q;
    term_d      = term_q;
    psub_d      = psub_q;
    pop_d       = pop_q;
    err_d       = err_q;
    act_d       = act_q;
    out_value_d = out_value_q;
    out_dbz_d   = out_dbz_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      iee_pkg::ST_IDLE: begin
        if (accept && act_valid) begin
          act_d = in_i.action;
          if ((pop_q == iee_pkg::POP_DIV) && x_zero) begin
            err_d  = 1'b1;
            term_d = '0;
          end else if (!need_arith) begin
            term_d = in_i.operand_value;
          end
        end
      end
      iee_pkg::ST_ARITH: begin
        if (md_done) begin
          term_d = md_res;
        end
      end
      iee_pkg::ST_POST: begin
        case (act_q)
          iee_pkg::ACT_MUL: pop_d = iee_pkg::POP_MUL;
          iee_pkg::ACT_DIV: pop_d = iee_pkg::POP_DIV;
          default: begin
            sum_d  = sum_sat;
            pop_d  = iee_pkg::POP_NONE;
            psub_d = (act_q == iee_pkg::ACT_MINUS);
          end
        endcase
      end
      iee_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_value_d = err_q ? '0 : sum_q;
          out_dbz_d   = err_q;
          sum_d       = '0;
          term_d      = '0;
          psub_d      = 1'b0;
          pop_d       = iee_pkg::POP_NONE;
          err_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_value   = out_value_q;
  assign out_o.divide_by_zero = out_dbz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iee_pkg::ST_IDLE;
      sum_q       <= '0;
      term_q      <= '0;
      psub_q      <= 1'b0;
      pop_q       <= iee_pkg::POP_NONE;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      psub_q      <= psub_d;
      pop_q       <= pop_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    out_value_q <= out_value_d;
    out_dbz_q   <= out_dbz_d;
  end

endmodule

// ===== design/iee_checker.sv =====
module iee_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input iee_pkg::action_t in_action_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input iee_pkg::value_t  out_result_i,
  input logic             out_dbz_i
);

  logic in_take;
  logic act_ok;

  assign in_take = in_valid_i && in_ready_i;
  assign act_ok  = (in_action_i == iee_pkg::ACT_PLUS)  || (in_action_i == iee_pkg::ACT_MINUS) ||
                   (in_action_i == iee_pkg::ACT_MUL)   || (in_action_i == iee_pkg::ACT_DIV)   ||
                   (in_action_i == iee_pkg::ACT_EQUALS);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && act_ok |=> !in_ready_i)
    else $error("input ready right after a valid item");

  a_ignored_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !act_ok |=> in_ready_i)
    else $error("unused action code held the input");

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_dbz_i |-> out_result_i == '0)
    else $error("divide-by-zero result is not zero");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_action_i  (in_i.action),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result_value),
  .out_dbz_i    (out_o.divide_by_zero)
);

// ===== dv/calc_result_checker.sv =====
module calc_result_checker
  import iee_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  iee_in_if           in_i,
  iee_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned open_results_o
);

  typedef struct packed {
    value_t result_value;
    logic   divide_by_zero;
  } calc_result_t;

  // Bounds of the signed range, held as magnitudes.
  localparam logic [127:0] POS_LIMIT = 128'(VALUE_MAX);
  localparam logic [127:0] NEG_LIMIT = POS_LIMIT + 128'd1;

  value_t       sum_acc;
  value_t       term_acc;
  logic         subtract_next;
  pop_e         term_op;
  logic         zero_divisor_seen;
  calc_result_t result_fifo[$];
  calc_result_t oldest_result;

  function automatic logic [127:0] abs_wide(value_t v);
    logic [VALUE_WIDTH:0] ext;
    ext = {v[VALUE_WIDTH-1], v};
    if (v[VALUE_WIDTH-1]) ext = -ext;
    return 128'(ext);
  endfunction

  function automatic value_t clamp_to_range(logic neg, logic [127:0] mag);
    if (neg) return (mag > NEG_LIMIT) ? VALUE_MIN : value_t'(-mag);
    return (mag > POS_LIMIT) ? VALUE_MAX : value_t'(mag);
  endfunction

  function automatic value_t sat_sum(value_t a, logic subtract, value_t b);
    logic signed [VALUE_WIDTH+1:0] total;
    total = subtract ? (a - b) : (a + b);
    if (total > VALUE_MAX) return VALUE_MAX;
    if (total < VALUE_MIN) return VALUE_MIN;
    return value_t'(total);
  endfunction

  // Both products and quotients work on magnitudes and truncate toward zero.
  function automatic value_t sat_product(value_t a, value_t b);
    logic [127:0] prod;
    prod = (abs_wide(a) * abs_wide(b)) >> FRACTION_BITS;
    return clamp_to_range(a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1], prod);
  endfunction

  function automatic value_t sat_quotient(value_t a, value_t b);
    logic [127:0] quot;
    quot = (abs_wide(a) << FRACTION_BITS) / abs_wide(b);
    return clamp_to_range(a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1], quot);
  endfunction

  task automatic clear_expression();
    sum_acc           = '0;
    term_acc          = '0;
    subtract_next     = 1'b0;
    term_op           = POP_NONE;
    zero_divisor_seen = 1'b0;
  endtask

  task automatic evaluate_item(value_t x, action_t act);
    calc_result_t res;
    if (act > ACT_EQUALS) return;
    case (term_op)
      POP_MUL: term_acc = sat_product(term_acc, x);
      POP_DIV: begin
        if (x == '0) begin
          zero_divisor_seen = 1'b1;
          term_acc          = '0;
        end else begin
          term_acc = sat_quotient(term_acc, x);
        end
      end
      default: term_acc = x;
    endcase
    if (act == ACT_MUL || act == ACT_DIV) begin
      term_op = (act == ACT_MUL) ? POP_MUL : POP_DIV;
      return;
    end
    sum_acc = sat_sum(sum_acc, subtract_next, term_acc);
    term_op = POP_NONE;
    if (act != ACT_EQUALS) begin
      subtract_next = (act == ACT_MINUS);
      return;
    end
    res.result_value   = zero_divisor_seen ? value_t'(0) : sum_acc;
    res.divide_by_zero = zero_divisor_seen;
    result_fifo = {result_fifo, res};
    clear_expression();
  endtask

  // Results leave before new items are taken in, so a result and an equals
  // item on the same edge are matched in the right order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_expression();
      result_fifo.delete();
      fail_count_o   = 0;
      open_results_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (result_fifo.size() == 0) begin
          fail_count_o++;
          $error("unexpected result: result_value %0d, divide_by_zero %0b",
                 out_i.result_value, out_i.divide_by_zero);
        end else begin
          oldest_result = result_fifo.pop_front();
          if (out_i.result_value !== oldest_result.result_value) begin
            fail_count_o++;
            $error("result_value: expected %0d, got %0d",
                   oldest_result.result_value, out_i.result_value);
          end
          if (out_i.divide_by_zero !== oldest_result.divide_by_zero) begin
            fail_count_o++;
            $error("divide_by_zero: expected %0b, got %0b",
                   oldest_result.divide_by_zero, out_i.divide_by_zero);
          end
        end
      end
      if (in_i.valid && in_i.ready) evaluate_item(in_i.operand_value, in_i.action);
      open_results_o = result_fifo.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import iee_pkg::*;

  // One whole unit in the fixed-point format.
  localparam value_t UNIT = value_t'(1) <<< FRACTION_BITS;

  // Action codes above equals are not operators; the block drops them.
  localparam action_t ACT_UNUSED_LO = ACT_EQUALS + action_t'(1);
  localparam action_t ACT_UNUSED_HI = '1;

  localparam int unsigned ITEM_COUNT   = 1750;
  localparam int unsigned IDLE_PERCENT = 19;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PAUSE_AT     = 900;
  localparam int unsigned BUSY_FROM    = 1100;
  localparam int unsigned BUSY_TO      = 1400;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned TAIL_CYCLES  = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        gaps_on = 1'b1;
  logic        hold_request = 1'b0;
  int unsigned items_sent = 0;
  int unsigned fail_count;
  int unsigned open_results;

  iee_in_if  in_ch ();
  iee_out_if out_ch ();

  infix_expression_evaluator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // The checker sees both channels, predicts every result and counts
  // mismatches; this module only drives stimulus and reports the verdict.
  calc_result_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_ch),
    .out_i          (out_ch),
    .fail_count_o   (fail_count),
    .open_results_o (open_results)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // A divide is the slowest kind of item, so even the slowest correct run of
  // about 1800 items with stalls on both sides stays far below this limit.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Operands mix corner values, fully random bit patterns (so every bit of
  // the field toggles) and moderate values with random fractions, which keep
  // most products and quotients inside the range.
  function automatic value_t pick_operand();
    value_t v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(6))
          0:       v = '0;
          1:       v = VALUE_MAX;
          2:       v = VALUE_MIN;
          3:       v = value_t'(1);
          4:       v = -value_t'(1);
          5:       v = UNIT;
          default: v = -UNIT;
        endcase
      end
      1, 2: v = value_t'({$urandom, $urandom});
      default: begin
        v = (value_t'($urandom_range(1000)) <<< FRACTION_BITS)
          | value_t'($urandom_range((1 << FRACTION_BITS) - 1));
        if ($urandom_range(1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  // Drives one item at the falling edge and returns at the falling edge after
  // it was taken, with valid still high. A gap lowers valid first, so valid
  // never sees two assignments in the same time step.
  task automatic send_item(value_t operand, action_t act);
    if (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operand_value <= operand;
    in_ch.action        <= act;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // One expression of one to six operands with random operators, mostly
  // closed by equals. About one in ten is left open and simply runs on into
  // the next one. Now and then an item with an unused code is slipped in; it
  // does not count toward the item total.
  task automatic send_expression();
    int unsigned terms;
    action_t     act;
    logic        after_divide;
    value_t      operand;
    terms        = $urandom_range(6, 1);
    after_divide = 1'b0;
    for (int unsigned t = 1; t <= terms; t++) begin
      if ($urandom_range(99) < 3)
        send_item(pick_operand(),
                  action_t'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO)));
      if (t == terms && $urandom_range(9) != 0)
        act = ACT_EQUALS;
      else
        act = action_t'($urandom_range(ACT_DIV));
      // A zero right after a divide hits the divide-by-zero path.
      operand = (after_divide && $urandom_range(19) == 0) ? value_t'(0) : pick_operand();
      send_item(operand, act);
      after_divide = (act == ACT_DIV);
      items_sent++;
    end
  endtask

  // The receiver decides ready at every falling edge. A hold request from the
  // stimulus makes it refuse results for a long stretch, counted here, while
  // items keep coming, so the block has to stall its input.
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  initial begin
    int unsigned drain_cycles;
    logic        hold_done;
    logic        pause_done;
    hold_done           = 1'b0;
    pause_done          = 1'b0;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operand_value = '0;
    in_ch.action        = ACT_PLUS;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Positive overflow of a sum saturates to the largest value.
    send_item(VALUE_MAX, ACT_PLUS);
    send_item(VALUE_MAX, ACT_EQUALS);
    // Negative overflow of a difference saturates to the smallest value.
    send_item(VALUE_MIN, ACT_MINUS);
    send_item(VALUE_MAX, ACT_EQUALS);
    // The most negative value squared overflows the product.
    send_item(VALUE_MIN, ACT_MUL);
    send_item(VALUE_MIN, ACT_EQUALS);
    // Division by zero poisons the whole expression, and later items still count.
    send_item(UNIT + (UNIT >>> 1), ACT_DIV);
    send_item('0, ACT_PLUS);
    send_item(UNIT * 3, ACT_EQUALS);
    // Negative quotient times minus the smallest step, each truncating toward zero.
    send_item(-(UNIT * 29) >>> 2, ACT_DIV);
    send_item(UNIT * 3, ACT_MUL);
    send_item(-value_t'(1), ACT_MINUS);
    send_item(UNIT * 2, ACT_EQUALS);
    // Unused codes in the middle of an expression leave it untouched.
    send_item(UNIT * 10, ACT_PLUS);
    send_item(VALUE_MAX, ACT_UNUSED_LO);
    send_item(VALUE_MIN, ACT_UNUSED_LO + action_t'(1));
    send_item(value_t'({$urandom, $urandom}), ACT_UNUSED_HI);
    send_item(UNIT * 4, ACT_EQUALS);
    // Dividing the smallest value by one step overflows the quotient.
    send_item(VALUE_MIN, ACT_DIV);
    send_item(value_t'(1), ACT_EQUALS);
    // Multiply binds tighter than plus: 2 + 3 * 4 gives 14.
    send_item(UNIT * 2, ACT_PLUS);
    send_item(UNIT * 3, ACT_MUL);
    send_item(UNIT * 4, ACT_EQUALS);
    // An equals on its own returns the operand.
    send_item('0, ACT_EQUALS);

    // Random part, with a long output hold, a full drain and a stretch where
    // neither side idles.
    while (items_sent < ITEM_COUNT) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && items_sent >= PAUSE_AT) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
        while (open_results != 0) @(negedge clk_i);
        pause_done = 1'b1;
      end
      gaps_on = !(items_sent >= BUSY_FROM && items_sent < BUSY_TO);
      send_expression();
    end

    // Close any expression left open so that its result is checked too.
    send_item(pick_operand(), ACT_EQUALS);
    in_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (open_results != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (open_results != 0) $error("%0d expected results never arrived", open_results);
    if (fail_count == 0 && open_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/iee_pkg.sv
design/iee_if.sv
design/iee_muldiv.sv
design/infix_expression_evaluator.sv
design/iee_checker.sv
dv/calc_result_checker.sv
dv/tb_top.sv
